/* sv/mtb_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// mtb_pkg: shared definitions of the multi time base timer bank
// Bank size, group bounds, field widths and the queued item format.
// ============================================================================
package mtb_pkg;

    // Bank size and group bounds (group ends are exclusive).
    localparam int NUM_TIMERS         = 32;
    localparam int FAST_GROUP_END     = 8;
    localparam int TENS_GROUP_END     = 16;
    localparam int HUNDREDS_GROUP_END = 24;

    // Bounds clipped to the bank size.
    localparam int FAST_END_C  = (FAST_GROUP_END > NUM_TIMERS) ? NUM_TIMERS : FAST_GROUP_END;
    localparam int TENS_END_C  = (TENS_GROUP_END > NUM_TIMERS) ? NUM_TIMERS : TENS_GROUP_END;
    localparam int HUNDS_END_C = (HUNDREDS_GROUP_END > NUM_TIMERS) ? NUM_TIMERS
                                                                   : HUNDREDS_GROUP_END;

    // Field widths.
    localparam int INDEX_W   = 5;
    localparam int PRESET_W  = 16;
    localparam int ELAPSED_W = 15;
    localparam int IDX_W     = $clog2(NUM_TIMERS);

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
    localparam logic [3:0]           PRESCALE_DIV = 4'd10;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_START,
        KIND_STOP,
        KIND_NULL
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [IDX_W-1:0]     idx;
        logic [PRESET_W-1:0]  preset;
    } t_item;

endpackage

/* sv/mtb_ifs.sv */
`timescale 1ns / 1ps
// ============================================================================
// mtb_ifs: request and response channels of the timer bank
// Valid/ready channels; a request moves when valid and ready are both high.
// ============================================================================
interface mtb_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic                          run;
    logic [mtb_pkg::INDEX_W-1:0]   timer_index;
    logic [mtb_pkg::PRESET_W-1:0]  preset;

    modport source (output valid, mode, run, timer_index, preset, input ready);
    modport sink   (input valid, mode, run, timer_index, preset, output ready);
endinterface

interface mtb_rsp_if;
    logic valid;
    logic ready;
    logic done_res;
    logic timer_status;

    modport source (output valid, done_res, timer_status, input ready);
    modport sink   (input valid, done_res, timer_status, output ready);
endinterface

/* sv/multi_timebase_timer_bank.sv */
`timescale 1ns / 1ps
// ============================================================================
// multi_timebase_timer_bank: bank of on-delay timers on four time bases
// Top level: request intake and queue, execution engine, assertions.
// ============================================================================
// Usage: i_req carries one request per handshake. With mode low it is a
// one-millisecond tick, which advances the divide-by-ten prescaler cascade
// and updates every enabled timer in the strobed groups (1, 10, 100 and
// 1000 tick time bases). With mode high it starts, queries or stops the
// timer at timer_index, and exactly one response comes back on o_rsp.
// Ticks give no response.
// A control request passes the request queue, is taken by the engine and
// loads the response register; a query of a running timer first reads the
// timer memory and loads the response from ST_QUERY.
// A tick holds the engine in ST_SCAN, which scans the timer memory one
// entry per cycle through its single read port; that scan sets the tick
// rate limit. Start of an idle timer, stop and requests beyond the bank
// are done in ST_IDLE.
// A two-entry request queue lets the intake keep taking requests while the
// engine scans or waits on a stalled response. When o_rsp is not taken, the
// response register holds and the engine waits before the next control
// request; ticks still proceed. Reset clears all timers, flags and the
// prescalers; no clearing pass is needed since disabled timers are skipped.
// ============================================================================
module multi_timebase_timer_bank (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtb_req_if.sink    i_req,
    mtb_rsp_if.source  o_rsp
);

    mtb_pkg::t_item item;
    logic           item_valid;
    logic           item_ready;

    // Intake: classifies each request and queues it for the engine.
    mtb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_ready (item_ready)
    );

    // Engine: prescalers, timer memory scan, and the response register.
    mtb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_ready (item_ready),
        .o_rsp        (o_rsp)
    );

    // The engine takes a control request only when the response slot frees.
    a_ctrl_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_valid && item_ready && (item.kind != mtb_pkg::KIND_TICK))
        |-> (!o_rsp.valid || o_rsp.ready))
        else $error("control request taken while response slot is busy");

    // A tick never produces a response.
    a_tick_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_valid && item_ready && (item.kind == mtb_pkg::KIND_TICK))
        |=> !$rose(o_rsp.valid))
        else $error("response raised by a tick");

    // A new response appears only after a control request was taken.
    a_rsp_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> !$past(item_valid && item_ready &&
                                      (item.kind == mtb_pkg::KIND_TICK)))
        else $error("response without a control request");

    // Reset empties the response register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("response valid after reset");

endmodule

/* sv/mtb_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// mtb_front: request intake and classification
// Sorts each request into tick, start, stop or ignored and queues it.
// ============================================================================
module mtb_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mtb_req_if.sink         i_req,
    output mtb_pkg::t_item  o_item,
    output logic            o_item_valid,
    input  logic            i_item_ready
);

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    mtb_pkg::t_item    r_buf [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    mtb_pkg::t_item    class_item;
    logic              push, pop;

    // Classify the incoming request.
    always_comb begin
        class_item.idx    = mtb_pkg::IDX_W'(i_req.timer_index);
        class_item.preset = i_req.preset;
        if (!i_req.mode) begin
            class_item.kind = mtb_pkg::KIND_TICK;
        end else if (int'(i_req.timer_index) >= mtb_pkg::NUM_TIMERS) begin
            class_item.kind = mtb_pkg::KIND_NULL;
        end else if (i_req.run) begin
            class_item.kind = mtb_pkg::KIND_START;
        end else begin
            class_item.kind = mtb_pkg::KIND_STOP;
        end
    end

    assign i_req.ready  = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_buf[r_rd_ptr];
    assign push         = i_req.valid && i_req.ready;
    assign pop          = o_item_valid && i_item_ready;

    always_comb begin
        n_wr_ptr = push ? PTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = pop  ? PTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (pop && !push) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= class_item;
        end
    end

endmodule

/* sv/mtb_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// mtb_back: timer execution engine
// Runs the prescaler cascade, scans the timer memory on ticks, and serves
// start, query and stop requests into a registered response.
// ============================================================================
module mtb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mtb_pkg::t_item  i_item,
    input  logic            i_item_valid,
    output logic            o_item_ready,
    mtb_rsp_if.source       o_rsp
);

    localparam int N     = mtb_pkg::NUM_TIMERS;
    localparam int IW    = mtb_pkg::IDX_W;
    localparam int EW    = mtb_pkg::ELAPSED_W;
    localparam int PW    = mtb_pkg::PRESET_W;
    localparam int MEM_W = PW + EW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_QUERY
    } t_state;

    // Number of strobed groups that contain timer k in this tick.
    function automatic logic [2:0] serve_count(input logic [IW-1:0] k,
                                               input logic s10, input logic s100,
                                               input logic s1000);
        int         kk;
        logic [2:0] cnt;
        kk  = int'(k);
        cnt = 3'd0;
        if (kk < mtb_pkg::FAST_END_C) cnt = cnt + 3'd1;
        if (s10 && kk >= mtb_pkg::FAST_END_C && kk < mtb_pkg::TENS_END_C) cnt = cnt + 3'd1;
        if (s100 && kk >= mtb_pkg::TENS_END_C && kk < mtb_pkg::HUNDS_END_C) cnt = cnt + 3'd1;
        if (s1000 && kk >= mtb_pkg::HUNDS_END_C) cnt = cnt + 3'd1;
        return cnt;
    endfunction

    // Timer memory: {preset, elapsed} per timer, one write and one read port.
    logic [MEM_W-1:0] r_mem [N];
    logic [MEM_W-1:0] r_rd_data;

    t_state         r_state, n_state;
    logic [IW-1:0]  r_idx, n_idx;
    logic [N-1:0]   r_enabled, n_enabled;
    logic [N-1:0]   r_flag, n_flag;
    logic [3:0]     r_ones, n_ones, r_tens, n_tens, r_hunds, n_hunds;
    logic           r_s10, n_s10, r_s100, n_s100, r_s1000, n_s1000;
    logic           r_out_valid, n_out_valid;
    logic           r_done, n_done;
    logic           r_status, n_status;

    logic              rd_en, wr_en;
    logic [IW-1:0]     rd_addr, wr_addr;
    logic [MEM_W-1:0]  wr_data;
    logic              out_free;

    logic [3:0]     ones_inc, tens_inc, hunds_inc;
    logic           s10, s100, s1000;

    logic [PW-1:0]  cur_pre;
    logic [EW-1:0]  cur_el;
    logic [2:0]     serves;
    logic [PW-1:0]  sum_all, sum_flag;
    logic [EW-1:0]  el_new, el_flag;
    logic           flag_new;

    // Divide-by-ten cascade for the next tick.
    always_comb begin
        ones_inc  = 4'(r_ones + 4'd1);
        s10       = (ones_inc >= mtb_pkg::PRESCALE_DIV);
        tens_inc  = s10 ? 4'(r_tens + 4'd1) : r_tens;
        s100      = (tens_inc >= mtb_pkg::PRESCALE_DIV);
        hunds_inc = s100 ? 4'(r_hunds + 4'd1) : r_hunds;
        s1000     = (hunds_inc >= mtb_pkg::PRESCALE_DIV);
    end

    // Update of the timer whose data was read in the last cycle. The groups do
    // not overlap, so a timer is served at most once per tick.
    always_comb begin
        cur_pre  = r_rd_data[MEM_W-1 -: PW];
        cur_el   = r_rd_data[EW-1:0];
        serves   = serve_count(r_idx, r_s10, r_s100, r_s1000);
        sum_all  = PW'({1'b0, cur_el}) + PW'(serves);
        sum_flag = PW'(sum_all - PW'(1));
        el_new   = (sum_all > PW'(mtb_pkg::ELAPSED_MAX)) ? mtb_pkg::ELAPSED_MAX
                                                        : sum_all[EW-1:0];
        el_flag  = (sum_flag > PW'(mtb_pkg::ELAPSED_MAX)) ? mtb_pkg::ELAPSED_MAX
                                                         : sum_flag[EW-1:0];
        flag_new = (PW'({1'b0, el_flag}) >= cur_pre);
    end

    assign out_free     = !r_out_valid || o_rsp.ready;
    assign o_item_ready = (r_state == ST_IDLE) &&
                          ((i_item.kind == mtb_pkg::KIND_TICK) || out_free);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_enabled   = r_enabled;
        n_flag      = r_flag;
        n_ones      = r_ones;
        n_tens      = r_tens;
        n_hunds     = r_hunds;
        n_s10       = r_s10;
        n_s100      = r_s100;
        n_s1000     = r_s1000;
        n_out_valid = r_out_valid;
        n_done      = r_done;
        n_status    = r_status;
        rd_en       = 1'b0;
        rd_addr     = r_idx;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = {cur_pre, el_new};

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid && o_item_ready) begin
                    unique case (i_item.kind)
                        mtb_pkg::KIND_TICK: begin
                            n_ones  = s10 ? 4'd0 : ones_inc;
                            n_tens  = s100 ? 4'd0 : tens_inc;
                            n_hunds = s1000 ? 4'd0 : hunds_inc;
                            n_s10   = s10;
                            n_s100  = s100;
                            n_s1000 = s1000;
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_idx   = '0;
                            n_state = ST_SCAN;
                        end
                        mtb_pkg::KIND_START: begin
                            if (r_enabled[i_item.idx]) begin
                                rd_en   = 1'b1;
                                rd_addr = i_item.idx;
                                n_idx   = i_item.idx;
                                n_state = ST_QUERY;
                            end else begin
                                wr_en                = 1'b1;
                                wr_addr              = i_item.idx;
                                wr_data              = {i_item.preset, {EW{1'b0}}};
                                n_enabled[i_item.idx] = 1'b1;
                                n_flag[i_item.idx]    = 1'b0;
                                n_out_valid          = 1'b1;
                                n_done               = 1'b0;
                                n_status             = 1'b0;
                            end
                        end
                        mtb_pkg::KIND_STOP: begin
                            n_enabled[i_item.idx] = 1'b0;
                            n_flag[i_item.idx]    = 1'b0;
                            n_out_valid          = 1'b1;
                            n_done               = 1'b0;
                            n_status             = 1'b0;
                        end
                        mtb_pkg::KIND_NULL: begin
                            n_out_valid = 1'b1;
                            n_done      = 1'b0;
                            n_status    = 1'b0;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_enabled[r_idx] && (serves != 3'd0)) begin
                    wr_en         = 1'b1;
                    n_flag[r_idx] = flag_new;
                end
                if (r_idx == IW'(N - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = IW'(r_idx + 1'b1);
                    n_idx   = IW'(r_idx + 1'b1);
                end
            end
            ST_QUERY: begin
                // Read data holds while the response register is full.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_done      = (PW'({1'b0, cur_el}) >= cur_pre);
                    n_status    = r_flag[r_idx];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_enabled   <= '0;
            r_flag      <= '0;
            r_ones      <= '0;
            r_tens      <= '0;
            r_hunds     <= '0;
            r_s10       <= 1'b0;
            r_s100      <= 1'b0;
            r_s1000     <= 1'b0;
            r_out_valid <= 1'b0;
            r_done      <= 1'b0;
            r_status    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_enabled   <= n_enabled;
            r_flag      <= n_flag;
            r_ones      <= n_ones;
            r_tens      <= n_tens;
            r_hunds     <= n_hunds;
            r_s10       <= n_s10;
            r_s100      <= n_s100;
            r_s1000     <= n_s1000;
            r_out_valid <= n_out_valid;
            r_done      <= n_done;
            r_status    <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.done_res     = r_done;
    assign o_rsp.timer_status = r_status;

endmodule

/* tb/tb_multi_timebase_timer_bank.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_multi_timebase_timer_bank: self-checking bench of the timer bank
// Drives ticks and start, query and stop requests through the request
// channel and predicts every control answer with a behavioral copy of the
// bank. Random idling on both channels, a tick run long enough for every
// time base to strobe, and a random mix of requests with no idling at the end.
// ============================================================================
module tb_multi_timebase_timer_bank;

    // Request encodings as seen on the request channel.
    typedef enum bit {
        MODE_TICK    = 1'b0,
        MODE_CONTROL = 1'b1
    } t_req_mode;

    typedef enum bit {
        RUN_STOP  = 1'b0,
        RUN_START = 1'b1
    } t_req_run;

    typedef struct packed {
        t_req_mode                     mode;
        t_req_run                      run;
        logic [mtb_pkg::INDEX_W-1:0]   idx;
        logic [mtb_pkg::PRESET_W-1:0]  preset;
    } t_bank_req;

    typedef struct packed {
        logic done_res;
        logic timer_status;
    } t_answer;

    // One row of the directed table. When answer_fixed is set, the answer
    // column is what the bank must return; otherwise the predictor decides.
    typedef struct packed {
        t_bank_req req;
        bit        answer_fixed;
        t_answer   answer;
    } t_directed_row;

    localparam int CYCLE_LIMIT   = 300_000;
    localparam int RANDOM_ITEMS  = 440;
    localparam int QUIET_ITEMS   = 150;
    localparam int SOAK_TICKS    = 1000;
    localparam int DRAIN_CYCLES  = 4 * (mtb_pkg::NUM_TIMERS + 1);
    localparam int DIRECTED_ROWS = 22;

    // The directed rows walk through: start of an idle timer, a query of a
    // running timer before and after a tick, stop of a running and of an
    // idle timer, the extreme indexes and presets, a tick whose control
    // fields are all ones (they must be ignored), and restart after stop.
    t_directed_row directed_table [DIRECTED_ROWS] = '{
        '{'{MODE_CONTROL, RUN_START, 5'd0,  16'd0},     1'b1, '{1'b0, 1'b0}},
        '{'{MODE_CONTROL, RUN_START, 5'd0,  16'd0},     1'b1, '{1'b1, 1'b0}},
        '{'{MODE_TICK,    RUN_STOP,  5'd0,  16'd0},     1'b0, '{1'b0, 1'b0}},
        '{'{MODE_CONTROL, RUN_START, 5'd0,  16'd9},     1'b0, '{1'b0, 1'b0}},
        '{'{MODE_CONTROL, RUN_STOP,  5'd0,  16'd0},     1'b1, '{1'b0, 1'b0}},
        '{'{MODE_CONTROL, RUN_STOP,  5'd0,  16'd0},     1'b1, '{1'b0, 1'b0}},
        '{'{MODE_CONTROL, RUN_START, 5'd31, 16'hFFFF},  1'b1, '{1'b0, 1'b0}},
        '{'{MODE_CONTROL, RUN_START, 5'd7,  16'd1},     1'b1, '{1'b0, 1'b0}},
        '{'{MODE_CONTROL, RUN_START, 5'd8,  16'd0},     1'b1, '{1'b0, 1'b0}},
        '{'{MODE_CONTROL, RUN_START, 5'd16, 16'd0},     1'b1, '{1'b0, 1'b0}},
        '{'{MODE_CONTROL, RUN_START, 5'd24, 16'd32767}, 1'b1, '{1'b0, 1'b0}},
        '{'{MODE_CONTROL, RUN_START, 5'd23, 16'd32768}, 1'b1, '{1'b0, 1'b0}},
        '{'{MODE_TICK,    RUN_START, 5'd31, 16'hFFFF},  1'b0, '{1'b0, 1'b0}},
        '{'{MODE_TICK,    RUN_STOP,  5'd0,  16'd0},     1'b0, '{1'b0, 1'b0}},
        '{'{MODE_CONTROL, RUN_START, 5'd7,  16'd0},     1'b0, '{1'b0, 1'b0}},
        '{'{MODE_CONTROL, RUN_START, 5'd8,  16'd0},     1'b0, '{1'b0, 1'b0}},
        '{'{MODE_CONTROL, RUN_START, 5'd31, 16'd0},     1'b0, '{1'b0, 1'b0}},
        '{'{MODE_CONTROL, RUN_STOP,  5'd31, 16'hFFFF},  1'b1, '{1'b0, 1'b0}},
        '{'{MODE_CONTROL, RUN_START, 5'd31, 16'd0},     1'b1, '{1'b0, 1'b0}},
        '{'{MODE_CONTROL, RUN_START, 5'd31, 16'd12345}, 1'b0, '{1'b0, 1'b0}},
        '{'{MODE_TICK,    RUN_STOP,  5'd0,  16'd0},     1'b0, '{1'b0, 1'b0}},
        '{'{MODE_CONTROL, RUN_START, 5'd23, 16'd0},     1'b0, '{1'b0, 1'b0}}
    };

    logic clk;
    logic rst_n;

    mtb_req_if req_if ();
    mtb_rsp_if rsp_if ();

    multi_timebase_timer_bank DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Behavioral copy of the bank state.
    bit                            bank_enabled [mtb_pkg::NUM_TIMERS];
    bit                            bank_flag    [mtb_pkg::NUM_TIMERS];
    logic [mtb_pkg::ELAPSED_W-1:0] bank_elapsed [mtb_pkg::NUM_TIMERS];
    logic [mtb_pkg::PRESET_W-1:0]  bank_preset  [mtb_pkg::NUM_TIMERS];
    logic [3:0]                    div_ones;
    logic [3:0]                    div_tens;
    logic [3:0]                    div_hundreds;

    // Answers still owed by the bank, oldest first.
    t_answer expected_answers [$];

    int      mismatch_count = 0;
    int      cycle_count    = 0;
    bit      src_idle_on;
    bit      sink_idle_on;
    t_answer oldest_answer;

    // ------------------------------------------------------------------------
    // Clock and cycle budget. The budget covers every request taking a full
    // tick scan plus the longest idling, several times over.
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction. A tick serves the 1 ms group, then ripples through the
    // divide-by-ten cascade; each stage that wraps serves its own group.
    // Within a group every running timer first latches (elapsed >= preset)
    // into its flag and then counts up, holding at the counter's maximum.
    // ------------------------------------------------------------------------
    function automatic void serve_timer_group(int first, int last);
        for (int k = first; k < last; k++) begin
            if (bank_enabled[k]) begin
                bank_flag[k] = ({1'b0, bank_elapsed[k]} >= bank_preset[k]);
                if (bank_elapsed[k] != mtb_pkg::ELAPSED_MAX)
                    bank_elapsed[k] = bank_elapsed[k] + 1'b1;
            end
        end
    endfunction

    // Applies one accepted request to the copy of the bank. Control requests
    // produce an answer; ticks produce none.
    function automatic bit advance_timer_bank(t_bank_req r, output t_answer ans);
        int k;
        ans = '0;
        if (r.mode == MODE_TICK) begin
            serve_timer_group(0, mtb_pkg::FAST_END_C);
            div_ones = div_ones + 1'b1;
            if (div_ones >= mtb_pkg::PRESCALE_DIV) begin
                serve_timer_group(mtb_pkg::FAST_END_C, mtb_pkg::TENS_END_C);
                div_ones = '0;
                div_tens = div_tens + 1'b1;
            end
            if (div_tens >= mtb_pkg::PRESCALE_DIV) begin
                serve_timer_group(mtb_pkg::TENS_END_C, mtb_pkg::HUNDS_END_C);
                div_tens     = '0;
                div_hundreds = div_hundreds + 1'b1;
            end
            if (div_hundreds >= mtb_pkg::PRESCALE_DIV) begin
                serve_timer_group(mtb_pkg::HUNDS_END_C, mtb_pkg::NUM_TIMERS);
                div_hundreds = '0;
            end
            return 1'b0;
        end
        k = int'(r.idx);
        // An index beyond the bank is answered with zeros and changes nothing.
        if (k < mtb_pkg::NUM_TIMERS) begin
            if (r.run == RUN_START) begin
                if (!bank_enabled[k]) begin
                    bank_preset[k]  = r.preset;
                    bank_elapsed[k] = '0;
                    bank_enabled[k] = 1'b1;
                    bank_flag[k]    = 1'b0;
                end else begin
                    ans.done_res = ({1'b0, bank_elapsed[k]} >= bank_preset[k]);
                end
            end else begin
                bank_enabled[k] = 1'b0;
                bank_flag[k]    = 1'b0;
            end
            ans.timer_status = bank_flag[k];
        end
        return 1'b1;
    endfunction

    function automatic t_bank_req make_request(t_req_mode mode, t_req_run run, int idx,
                                               logic [mtb_pkg::PRESET_W-1:0] preset);
        t_bank_req r;
        r.mode   = mode;
        r.run    = run;
        r.idx    = idx[mtb_pkg::INDEX_W-1:0];
        r.preset = preset;
        return r;
    endfunction

    // Presets are mostly small so that timers actually time out during the
    // run; the rest are moderate, fully random or sit at the saturation boundary.
    function automatic logic [mtb_pkg::PRESET_W-1:0] pick_preset();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return mtb_pkg::PRESET_W'($urandom_range(0, 20));
        else if (roll < 75)
            return mtb_pkg::PRESET_W'($urandom_range(0, 300));
        else if (roll < 90)
            return mtb_pkg::PRESET_W'($urandom);
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'd32767;
            2:       return 16'd32768;
            default: return 16'hFFFF;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. Called right after a rising edge; optionally drops
    // valid for a burst, then presents the request and waits for the
    // handshake. The expected answer is queued at the accepting edge, before the
    // bank can answer.
    // ------------------------------------------------------------------------
    task automatic send_request(t_bank_req r, bit answer_fixed, t_answer fixed_answer);
        t_answer predicted;
        bit      answers;
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.mode        <= r.mode;
        req_if.run         <= r.run;
        req_if.timer_index <= r.idx;
        req_if.preset      <= r.preset;
        do @(posedge clk); while (!req_if.ready);
        answers = advance_timer_bank(r, predicted);
        if (answers)
            expected_answers.push_back(answer_fixed ? fixed_answer : predicted);
    endtask

    // ------------------------------------------------------------------------
    // Response side: ready follows the current idling setting; while idling
    // is on, it drops low in bursts.
    // ------------------------------------------------------------------------
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(posedge clk);
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Answer checker: every accepted response is matched against the oldest
    // expectation. Values are sampled at the edge, before any update of it.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_answers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] unexpected response: done_res=%0b timer_status=%0b",
                             $time, rsp_if.done_res, rsp_if.timer_status);
            end else begin
                oldest_answer = expected_answers.pop_front();
                if (rsp_if.done_res !== oldest_answer.done_res ||
                    rsp_if.timer_status !== oldest_answer.timer_status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"[%0t] response mismatch: expected done_res=%0b ",
                                  "timer_status=%0b, got done_res=%0b timer_status=%0b"},
                                 $time, oldest_answer.done_res,
                                 oldest_answer.timer_status,
                                 rsp_if.done_res, rsp_if.timer_status);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned    soak_idx    [5] = '{1, 2, 3, 20, 28};
        logic [15:0]    soak_preset [5] = '{16'd500, 16'd32767, 16'hFFFF,
                                            16'd5, 16'd0};
        t_bank_req      r;

        // Everything the bench drives is known from time zero.
        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.mode        = 1'b0;
        req_if.run         = 1'b0;
        req_if.timer_index = '0;
        req_if.preset      = '0;
        src_idle_on        = 1'b1;
        sink_idle_on       = 1'b1;
        for (int k = 0; k < mtb_pkg::NUM_TIMERS; k++) begin
            bank_enabled[k] = 1'b0;
            bank_flag[k]    = 1'b0;
            bank_elapsed[k] = '0;
            bank_preset[k]  = '0;
        end
        div_ones     = '0;
        div_tens     = '0;
        div_hundreds = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table, with idling on both sides.
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(directed_table[i].req, directed_table[i].answer_fixed,
                         directed_table[i].answer);

        // Tick run: restart a few timers in the 1 ms, 100 ms and 1 s groups with
        // presets that time out and presets at and beyond the counter's maximum,
        // then tick long enough for the 1 s group to strobe. Idling is off here to
        // keep the run short. Every timer then gets a start, a query if it runs.
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        for (int i = 0; i < 5; i++) begin
            send_request(make_request(MODE_CONTROL, RUN_STOP, soak_idx[i], 16'd0),
                         1'b0, '0);
            send_request(make_request(MODE_CONTROL, RUN_START, soak_idx[i],
                                      soak_preset[i]), 1'b0, '0);
        end
        repeat (SOAK_TICKS)
            send_request(make_request(MODE_TICK, RUN_STOP, 0, 16'd0), 1'b0, '0);
        for (int k = 0; k < mtb_pkg::NUM_TIMERS; k++)
            send_request(make_request(MODE_CONTROL, RUN_START, k, 16'd0), 1'b0, '0);

        // Random mix. Idling on each side is switched every 100 requests so
        // that some stretches run flat out; the last requests have none.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= RANDOM_ITEMS - QUIET_ITEMS) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end else if (i % 100 == 0) begin
                src_idle_on  = ($urandom_range(0, 2) != 0);
                sink_idle_on = ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 99) < 55) begin
                // Tick; the control fields carry noise that must be ignored.
                r = make_request(MODE_TICK, t_req_run'($urandom_range(0, 1)),
                                 $urandom_range(0, mtb_pkg::NUM_TIMERS - 1),
                                 mtb_pkg::PRESET_W'($urandom));
            end else begin
                r = make_request(MODE_CONTROL,
                                 t_req_run'(($urandom_range(0, 99) < 70) ? RUN_START
                                                                         : RUN_STOP),
                                 $urandom_range(0, mtb_pkg::NUM_TIMERS - 1),
                                 pick_preset());
            end
            send_request(r, 1'b0, '0);
        end
        req_if.valid <= 1'b0;

        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
sv/mtb_pkg.sv
sv/mtb_ifs.sv
sv/mtb_front.sv
sv/mtb_back.sv
sv/multi_timebase_timer_bank.sv
tb/tb_multi_timebase_timer_bank.sv
